// ===== hw/rtl/skein512_ubi_compress_top_macros.svh =====
// ----------------------------------------------------------------------------
// Skein-512 UBI compression - assertion macros
// Concurrent assertion shorthands used by the compression top level.
// ----------------------------------------------------------------------------
`ifndef SKEIN512_UBI_COMPRESS_TOP_MACROS_SVH
`define SKEIN512_UBI_COMPRESS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SKN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SKN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SKN_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SKN_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/skn_pkg.sv =====
// ----------------------------------------------------------------------------
// Skein-512 UBI compression - package
// Word types, action codes, Threefish-512 rotation and permutation tables.
// ----------------------------------------------------------------------------
package skn_pkg;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] word_value;
      logic [2:0]  word_index;
      logic [6:0]  block_bytes;
      logic        last_block;
   } skn_req_type;

   typedef struct packed {
      logic [63:0] chaining_word;
      logic [2:0]  out_index;
      logic        last_word;
   } skn_rsp_type;

   typedef logic [7:0][63:0] skn_state_type;

   localparam logic [1:0] ACT_CHAIN = 2'd0;
   localparam logic [1:0] ACT_TWEAK = 2'd1;
   localparam logic [1:0] ACT_MSG   = 2'd2;

   localparam logic [63:0] KEY_PARITY_INIT = 64'h5555_5555_5555_5555;
   localparam logic [63:0] FIRST_FLAG      = 64'h4000_0000_0000_0000;

   localparam logic [6:0] ROUND_END = 7'd72;
   localparam logic [4:0] INJ_LAST  = 5'd18;
   localparam logic [4:0] INJ_DONE  = 5'd19;

   localparam logic [5:0] ROT_TAB [8][4] = '{
      '{6'd38, 6'd30, 6'd50, 6'd53},
      '{6'd48, 6'd20, 6'd43, 6'd31},
      '{6'd34, 6'd14, 6'd15, 6'd27},
      '{6'd26, 6'd12, 6'd58, 6'd7},
      '{6'd33, 6'd49, 6'd8,  6'd42},
      '{6'd39, 6'd27, 6'd41, 6'd14},
      '{6'd29, 6'd26, 6'd11, 6'd9},
      '{6'd33, 6'd51, 6'd39, 6'd35}
   };

   // adder word and rotated word of each MIX, by round position
   localparam logic [2:0] PAIR_A [4][4] = '{
      '{3'd0, 3'd2, 3'd4, 3'd6},
      '{3'd2, 3'd4, 3'd6, 3'd0},
      '{3'd4, 3'd6, 3'd0, 3'd2},
      '{3'd6, 3'd0, 3'd2, 3'd4}
   };

   localparam logic [2:0] PAIR_B [4][4] = '{
      '{3'd1, 3'd3, 3'd5, 3'd7},
      '{3'd1, 3'd7, 3'd5, 3'd3},
      '{3'd1, 3'd3, 3'd5, 3'd7},
      '{3'd1, 3'd7, 3'd5, 3'd3}
   };

   function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
      logic [127:0] t;
      t = {x, x} << r;
      return t[127:64];
   endfunction

endpackage

// ===== hw/rtl/skn_round.sv =====
// ----------------------------------------------------------------------------
// Skein-512 UBI compression - MIX round
// One Threefish-512 round: four MIX functions with the round's permutation.
// ----------------------------------------------------------------------------
module skn_round
   import skn_pkg::*;
(
   input  skn_state_type state_in,
   input  logic [2:0]    row,
   output skn_state_type state_out
);

   always_comb begin
      logic [1:0]  pos;
      logic [2:0]  a;
      logic [2:0]  b;
      logic [63:0] sum;
      pos       = row[1:0];
      state_out = state_in;
      for (int j = 0; j < 4; j++) begin
         a            = PAIR_A[pos][j];
         b            = PAIR_B[pos][j];
         sum          = state_in[a] + state_in[b];
         state_out[a] = sum;
         state_out[b] = rotl64(state_in[b], ROT_TAB[row][j]) ^ sum;
      end
   end

endmodule

// ===== hw/rtl/skein512_ubi_compress_top.sv =====
// Sequence: load words and message words 0 to 6 are stored while idle; message word 7
// starts a compression (19 subkey injections and 72 rounds, then a feed-forward
// step), after which the first word of a last block is registered in ST_EMIT.
// Throughput: one round or one subkey injection per cycle, input stalled meanwhile;
// a last block then emits eight words, one per cycle without stall.
// Reset: synchronous, active high; control state clears, word stores do not.
// ----------------------------------------------------------------------------
// Skein-512 UBI compression - top level
// Chaining and tweak stores, key schedule, round sequencer and output register.
// ----------------------------------------------------------------------------
`include "skein512_ubi_compress_top_macros.svh"

module skein512_ubi_compress_top
   import skn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  skn_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output skn_rsp_type rsp_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INJ,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   state_type       state_ff;
   logic [6:0]      rnd_ff;
   logic [4:0]      s_ff;
   logic [2:0]      emit_ff;
   logic            last_ff;
   logic            rsp_valid_ff;
   skn_rsp_type     rsp_word_ff;

   skn_state_type   chain_ff;
   skn_state_type   msg_ff;
   skn_state_type   cipher_ff;
   logic [1:0][63:0] tweak_ff;
   logic [8:0][63:0] key_ff;
   logic [2:0][63:0] tw_ff;

   skn_state_type   msg_in;
   skn_state_type   inj_out;
   skn_state_type   round_out;
   logic [63:0]     parity;
   logic [63:0]     tw0;
   logic            req_fire;
   logic            start;
   logic            rsp_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign start     = req_fire && (req_word.action == ACT_MSG) && (req_word.word_index == 3'd7);
   assign rsp_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign tw0 = tweak_ff[0] + {57'd0, req_word.block_bytes};

   always_comb begin
      parity = KEY_PARITY_INIT;
      for (int i = 0; i < 8; i++) begin
         parity = parity ^ chain_ff[i];
      end
      msg_in    = msg_ff;
      msg_in[7] = req_word.word_value;
   end

   always_comb begin
      logic [7:0][63:0] extra;
      extra    = '0;
      extra[5] = tw_ff[0];
      extra[6] = tw_ff[1];
      extra[7] = {59'd0, s_ff};
      for (int i = 0; i < 8; i++) begin
         inj_out[i] = cipher_ff[i] + key_ff[i] + extra[i];
      end
   end

   skn_round u_round (
      .state_in  (cipher_ff),
      .row       (rnd_ff[2:0]),
      .state_out (round_out)
   );

   // word stores and key schedule
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_word.action)
                  ACT_CHAIN: begin
                     chain_ff[req_word.word_index] <= req_word.word_value;
                  end
                  ACT_TWEAK: begin
                     if (req_word.word_index[2:1] == 2'd0) begin
                        tweak_ff[req_word.word_index[0]] <= req_word.word_value;
                     end
                  end
                  ACT_MSG: begin
                     msg_ff[req_word.word_index] <= req_word.word_value;
                     if (start) begin
                        for (int i = 0; i < 8; i++) begin
                           key_ff[i] <= chain_ff[i];
                        end
                        key_ff[8]   <= parity;
                        tw_ff[0]    <= tw0;
                        tw_ff[1]    <= tweak_ff[1];
                        tw_ff[2]    <= tw0 ^ tweak_ff[1];
                        tweak_ff[0] <= tw0;
                        tweak_ff[1] <= tweak_ff[1] & ~FIRST_FLAG;
                        cipher_ff   <= msg_in;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INJ: begin
            cipher_ff <= inj_out;
            for (int i = 0; i < 8; i++) begin
               key_ff[i] <= key_ff[i + 1];
            end
            key_ff[8] <= key_ff[0];
            tw_ff[0]  <= tw_ff[1];
            tw_ff[1]  <= tw_ff[2];
            tw_ff[2]  <= tw_ff[0];
         end
         ST_ROUND: begin
            cipher_ff <= round_out;
         end
         ST_FINAL: begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= cipher_ff[i] ^ msg_ff[i];
            end
         end
         ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         s_ff         <= '0;
         emit_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  last_ff  <= req_word.last_block;
                  rnd_ff   <= '0;
                  s_ff     <= '0;
                  state_ff <= ST_INJ;
               end
            end
            ST_INJ: begin
               s_ff <= s_ff + 5'd1;
               if (s_ff == INJ_LAST) begin
                  state_ff <= ST_FINAL;
               end else begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               rnd_ff <= rnd_ff + 7'd1;
               if (rnd_ff[1:0] == 2'd3) begin
                  state_ff <= ST_INJ;
               end
            end
            ST_FINAL: begin
               emit_ff  <= '0;
               state_ff <= last_ff ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
               if (rsp_load) begin
                  rsp_word_ff.chaining_word <= chain_ff[emit_ff];
                  rsp_word_ff.out_index     <= emit_ff;
                  rsp_word_ff.last_word     <= (emit_ff == 3'd7);
                  emit_ff                   <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `SKN_ASSERT_NEXT(a_start_inj, clock, reset, start, state_ff == ST_INJ)
   `SKN_ASSERT_IMPLY(a_final_count, clock, reset, state_ff == ST_FINAL, (rnd_ff == ROUND_END) && (s_ff == INJ_DONE))
   `SKN_ASSERT_IMPLY(a_last_word, clock, reset, rsp_valid_ff, rsp_word_ff.last_word == (rsp_word_ff.out_index == 3'd7))

endmodule

// ===== bench/skein512_ubi_compress_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skein-512 UBI compression - testbench
// Loads chaining and tweak words, then streams message blocks into the block.
// An independent Threefish-512 predictor works out each emitted chaining
// value. Results are checked in order, field by field, while both sides idle
// at random, the receiver holds off once for a long stretch, and the sender
// pauses between phases.
// ----------------------------------------------------------------------------
module skein512_ubi_compress_top_test;
   import skn_pkg::*;

   localparam logic [1:0]  ACT_IGNORED  = 2'd3;
   localparam logic [63:0] PARITY_SEED  = 64'h5555_5555_5555_5555;
   localparam int          FIRST_BIT    = 62;
   localparam int          ROUNDS       = 72;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 120;
   localparam int          PHASE_WORDS  = 170;

   // rotation amounts, row-major [round mod 8][mix]
   localparam bit [0:31][5:0] ROT_AMOUNT = {
      6'd38, 6'd30, 6'd50, 6'd53,  6'd48, 6'd20, 6'd43, 6'd31,
      6'd34, 6'd14, 6'd15, 6'd27,  6'd26, 6'd12, 6'd58, 6'd7,
      6'd33, 6'd49, 6'd8,  6'd42,  6'd39, 6'd27, 6'd41, 6'd14,
      6'd29, 6'd26, 6'd11, 6'd9,   6'd33, 6'd51, 6'd39, 6'd35
   };
   // MIX operands, [round mod 4][mix]
   localparam bit [0:15][2:0] MIX_ADD = {
      3'd0, 3'd2, 3'd4, 3'd6,  3'd2, 3'd4, 3'd6, 3'd0,
      3'd4, 3'd6, 3'd0, 3'd2,  3'd6, 3'd0, 3'd2, 3'd4
   };
   localparam bit [0:15][2:0] MIX_ROT = {
      3'd1, 3'd3, 3'd5, 3'd7,  3'd1, 3'd7, 3'd5, 3'd3,
      3'd1, 3'd3, 3'd5, 3'd7,  3'd1, 3'd7, 3'd5, 3'd3
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   skn_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   skn_rsp_type rsp_word;

   skein512_ubi_compress_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   logic [63:0] chain_value [8];
   logic [63:0] tweak_value [2];
   logic [63:0] msg_value [8];

   skn_req_type pending_words [$];
   skn_rsp_type expected_chain [$];
   skn_rsp_type want;

   int  pushed_total = 0;
   int  fail_count   = 0;
   int  req_idle_pct = 9;
   int  rsp_idle_pct = 50;
   int  hold_asked   = 0;
   int  hold_served  = 0;
   int  hold_left    = 0;
   bit  req_taken    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] rot_left(logic [63:0] x, int n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic void threefish_ubi(logic [6:0] bytes);
      logic [63:0] key [9];
      logic [63:0] tw [3];
      logic [63:0] c [8];
      int s, a, b, pos, row, i, j, r;
      tw[0] = tweak_value[0] + 64'(bytes);
      tw[1] = tweak_value[1];
      tw[2] = tw[0] ^ tw[1];
      key[8] = PARITY_SEED;
      for (i = 0; i < 8; i++) begin
         key[i] = chain_value[i];
         key[8] = key[8] ^ key[i];
         c[i] = key[i] + msg_value[i];
      end
      c[5] = c[5] + tw[0];
      c[6] = c[6] + tw[1];
      for (r = 0; r < ROUNDS; r++) begin
         pos = r % 4;
         row = r % 8;
         for (j = 0; j < 4; j++) begin
            a = MIX_ADD[pos * 4 + j];
            b = MIX_ROT[pos * 4 + j];
            c[a] = c[a] + c[b];
            c[b] = rot_left(c[b], ROT_AMOUNT[row * 4 + j]) ^ c[a];
         end
         if (pos == 3) begin
            s = (r + 1) / 4;
            for (i = 0; i < 8; i++)
               c[i] = c[i] + key[(s + i) % 9];
            c[5] = c[5] + tw[s % 3];
            c[6] = c[6] + tw[(s + 1) % 3];
            c[7] = c[7] + 64'(s);
         end
      end
      for (i = 0; i < 8; i++)
         chain_value[i] = c[i] ^ msg_value[i];
      tweak_value[0] = tw[0];
      tweak_value[1] = tw[1];
      tweak_value[1][FIRST_BIT] = 1'b0;
   endfunction

   function automatic void absorb_word(skn_req_type w);
      skn_rsp_type r;
      int i;
      case (w.action)
         ACT_CHAIN: chain_value[w.word_index] = w.word_value;
         ACT_TWEAK: if (w.word_index < 3'd2) tweak_value[w.word_index[0]] = w.word_value;
         ACT_MSG: begin
            msg_value[w.word_index] = w.word_value;
            if (w.word_index == 3'd7) begin
               threefish_ubi(w.block_bytes);
               if (w.last_block) begin
                  for (i = 0; i < 8; i++) begin
                     r.chaining_word = chain_value[i];
                     r.out_index     = 3'(i);
                     r.last_word     = (i == 7);
                     expected_chain.push_back(r);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic void push_word(logic [1:0] act, logic [63:0] val, logic [2:0] idx,
                                     logic [6:0] bytes, logic last);
      skn_req_type w;
      w.action      = act;
      w.word_value  = val;
      w.word_index  = idx;
      w.block_bytes = bytes;
      w.last_block  = last;
      pending_words.push_back(w);
      pushed_total++;
   endfunction

   // block count and last flag are don't-care on loads and early message words
   function automatic void push_plain(logic [1:0] act, logic [63:0] val, logic [2:0] idx);
      push_word(act, val, idx, 7'($urandom_range(127)), 1'($urandom_range(1)));
   endfunction

   function automatic void queue_random_block();
      int i, n;
      bit whole;
      logic [63:0] tw1;
      if ($urandom_range(99) < 10) begin
         n = $urandom_range(1, 3);
         for (i = 0; i < n; i++)
            push_plain(2'($urandom_range(3)), rand64(), 3'($urandom_range(7)));
         return;
      end
      if ($urandom_range(99) < 20)
         for (i = 0; i < 8; i++)
            push_plain(ACT_CHAIN, rand64(), 3'(i));
      if ($urandom_range(99) < 30) begin
         tw1 = rand64();
         tw1[FIRST_BIT] = $urandom_range(99) < 70;
         push_plain(ACT_TWEAK, rand64(), 3'd0);
         push_plain(ACT_TWEAK, tw1, 3'd1);
      end
      whole = $urandom_range(99) < 85;
      for (i = 0; i < 7; i++)
         if (whole || $urandom_range(1))
            push_plain(ACT_MSG, rand64(), 3'(i));
      push_word(ACT_MSG, rand64(), 3'd7,
                ($urandom_range(99) < 10) ? 7'($urandom_range(127)) : 7'($urandom_range(64)),
                1'($urandom_range(1)));
   endfunction

   function automatic void queue_random_words(int count);
      int start;
      start = pushed_total;
      while (pushed_total - start < count)
         queue_random_block();
   endfunction

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_chain.size() != 0)
         @(posedge clock);
   endtask

   // request side
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken)
         absorb_word(req_word);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_valid <= 1'b1;
            req_word  <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side
   always @(negedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < rsp_idle_pct;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chain.size() == 0) begin
            $display("%0t: unexpected word: got %h idx %0d last %0b", $time,
                     rsp_word.chaining_word, rsp_word.out_index, rsp_word.last_word);
            fail_count++;
         end else begin
            want = expected_chain.pop_front();
            if (rsp_word.chaining_word !== want.chaining_word ||
                rsp_word.out_index !== want.out_index ||
                rsp_word.last_word !== want.last_word) begin
               $display("%0t: mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                        $time, want.chaining_word, want.out_index, want.last_word,
                        rsp_word.chaining_word, rsp_word.out_index, rsp_word.last_word);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme chaining words, tweak wrap, ignored loads
      push_plain(ACT_CHAIN, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0);
      push_plain(ACT_CHAIN, 64'h0, 3'd1);
      push_plain(ACT_CHAIN, 64'h8000_0000_0000_0000, 3'd2);
      push_plain(ACT_CHAIN, 64'h1, 3'd3);
      push_plain(ACT_CHAIN, 64'h5555_5555_5555_5555, 3'd4);
      push_plain(ACT_CHAIN, 64'hAAAA_AAAA_AAAA_AAAA, 3'd5);
      push_plain(ACT_CHAIN, rand64(), 3'd6);
      push_plain(ACT_CHAIN, rand64(), 3'd7);
      push_plain(ACT_TWEAK, 64'hFFFF_FFFF_FFFF_FFF0, 3'd0);
      push_plain(ACT_TWEAK, 64'h7000_0000_0000_0000, 3'd1);
      push_plain(ACT_TWEAK, 64'hFFFF_FFFF_FFFF_FFFF, 3'd2);
      push_plain(ACT_TWEAK, 64'h0, 3'd7);
      push_plain(ACT_IGNORED, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7);
      push_plain(ACT_MSG, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0);
      push_plain(ACT_MSG, 64'h0, 3'd1);
      push_plain(ACT_MSG, 64'h8000_0000_0000_0001, 3'd2);
      push_plain(ACT_MSG, 64'hAAAA_AAAA_AAAA_AAAA, 3'd3);
      push_plain(ACT_MSG, 64'h5555_5555_5555_5555, 3'd4);
      push_plain(ACT_MSG, rand64(), 3'd5);
      push_plain(ACT_MSG, rand64(), 3'd6);
      push_word(ACT_MSG, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 7'd64, 1'b1);
      // stale words reused, oversize count, then empty count
      push_word(ACT_MSG, 64'h0, 3'd7, 7'd127, 1'b0);
      push_word(ACT_MSG, rand64(), 3'd7, 7'd0, 1'b1);
      wait_drained();

      queue_random_words(PHASE_WORDS);
      wait_drained();

      req_idle_pct = 50;
      rsp_idle_pct = 9;
      queue_random_words(PHASE_WORDS);
      wait_drained();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      queue_random_words(PHASE_WORDS);
      hold_asked++;
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
